@@ rtl/core/bfpea_pkg.sv @@
`default_nettype none
package bfpea_pkg;

    // Parameter defaults
    localparam int DEF_MAX_EXTENTS      = 64;
    localparam int DEF_PAGE_NUMBER_BITS = 20;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFIT  = 2'd1;
    localparam logic [1:0] STAT_DOUBLE = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } ctrl_state_t;

    // Width of the scan record that walks down the cell row
    function automatic int rec_width(input int pb, input int iw);
        return 10 + 8 * pb + 4 * iw;
    endfunction

    // Width of the table update command broadcast to all cells
    function automatic int cmd_width(input int pb, input int iw);
        return 3 + 2 * iw + 2 * pb;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bfpea_cell.sv @@
`default_nettype none
module bfpea_cell import bfpea_pkg::*; #(
    parameter int MAX_EXTENTS      = DEF_MAX_EXTENTS,
    parameter int PAGE_NUMBER_BITS = DEF_PAGE_NUMBER_BITS,
    parameter int INDEX            = 0,
    localparam int IW = $clog2(MAX_EXTENTS),
    localparam int PB = PAGE_NUMBER_BITS,
    localparam int LW = PAGE_NUMBER_BITS + 1,
    localparam int RW = rec_width(PAGE_NUMBER_BITS, IW),
    localparam int CW = cmd_width(PAGE_NUMBER_BITS, IW)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [RW-1:0] rec_in,
    output logic      [RW-1:0] rec_out,
    input  wire logic [CW-1:0] cmd
);

    typedef struct packed {
        logic          act;
        logic          kind;
        logic [PB-1:0] base;
        logic [LW-1:0] cnt;
        logic          b_ok;
        logic [IW-1:0] b_idx;
        logic [PB-1:0] b_base;
        logic [LW-1:0] b_len;
        logic          p_ok;
        logic [IW-1:0] p_idx;
        logic [PB-1:0] p_base;
        logic [LW-1:0] p_len;
        logic          n_ok;
        logic [IW-1:0] n_idx;
        logic [PB-1:0] n_base;
        logic [LW-1:0] n_len;
        logic          e_ok;
        logic [IW-1:0] e_idx;
    } rec_t;

    typedef struct packed {
        logic          wr_en;
        logic [IW-1:0] wr_idx;
        logic [PB-1:0] wr_base;
        logic [LW-1:0] wr_len;
        logic          clr_en;
        logic [IW-1:0] clr_idx;
    } cmd_t;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [PB-1:0] base_reg;
    logic [LW-1:0] len_reg;
    logic          valid_reg;
    rec_t          rec_reg;
    rec_t          rec_next;
    rec_t          r;
    cmd_t          c;

    assign r = rec_t'(rec_in);
    assign c = cmd_t'(cmd);
    assign rec_out = RW'(rec_reg);

    // Fold this cell's extent into the passing record
    always_comb begin
        rec_next = r;
        if (r.kind == KIND_ALLOC) begin
            if (valid_reg && len_reg >= r.cnt &&
                (!r.b_ok || len_reg < r.b_len ||
                 (len_reg == r.b_len && base_reg < r.b_base))) begin
                rec_next.b_ok   = 1'b1;
                rec_next.b_idx  = MY_IDX;
                rec_next.b_base = base_reg;
                rec_next.b_len  = len_reg;
            end
        end else begin
            if (!valid_reg) begin
                if (!r.e_ok) begin
                    rec_next.e_ok  = 1'b1;
                    rec_next.e_idx = MY_IDX;
                end
            end else if (base_reg <= r.base) begin
                if (!r.p_ok || base_reg > r.p_base) begin
                    rec_next.p_ok   = 1'b1;
                    rec_next.p_idx  = MY_IDX;
                    rec_next.p_base = base_reg;
                    rec_next.p_len  = len_reg;
                end
            end else begin
                if (!r.n_ok || base_reg < r.n_base) begin
                    rec_next.n_ok   = 1'b1;
                    rec_next.n_idx  = MY_IDX;
                    rec_next.n_base = base_reg;
                    rec_next.n_len  = len_reg;
                end
            end
        end
    end

    // Advance the record to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    // Apply table updates aimed at this slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (c.wr_en && c.wr_idx == MY_IDX) begin
                valid_reg <= 1'b1;
            end
            if (c.clr_en && c.clr_idx == MY_IDX) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c.wr_en && c.wr_idx == MY_IDX) begin
            base_reg <= c.wr_base;
            len_reg  <= c.wr_len;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/bfpea_ctrl.sv @@
`default_nettype none
module bfpea_ctrl import bfpea_pkg::*; #(
    parameter int MAX_EXTENTS      = DEF_MAX_EXTENTS,
    parameter int PAGE_NUMBER_BITS = DEF_PAGE_NUMBER_BITS,
    localparam int IW  = $clog2(MAX_EXTENTS),
    localparam int PB  = PAGE_NUMBER_BITS,
    localparam int LW  = PAGE_NUMBER_BITS + 1,
    localparam int RW  = rec_width(PAGE_NUMBER_BITS, IW),
    localparam int CW  = cmd_width(PAGE_NUMBER_BITS, IW),
    localparam int IDW = ((2 * PAGE_NUMBER_BITS + 1 + 7) / 8) * 8,
    localparam int ODW = ((PAGE_NUMBER_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [IDW-1:0] s_tdata,
    input  wire logic           s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [ODW-1:0] m_tdata,
    output logic      [RW-1:0]  rec_head,
    input  wire logic [RW-1:0]  rec_tail,
    output logic      [CW-1:0]  cmd
);

    typedef struct packed {
        logic          act;
        logic          kind;
        logic [PB-1:0] base;
        logic [LW-1:0] cnt;
        logic          b_ok;
        logic [IW-1:0] b_idx;
        logic [PB-1:0] b_base;
        logic [LW-1:0] b_len;
        logic          p_ok;
        logic [IW-1:0] p_idx;
        logic [PB-1:0] p_base;
        logic [LW-1:0] p_len;
        logic          n_ok;
        logic [IW-1:0] n_idx;
        logic [PB-1:0] n_base;
        logic [LW-1:0] n_len;
        logic          e_ok;
        logic [IW-1:0] e_idx;
    } rec_t;

    typedef struct packed {
        logic          wr_en;
        logic [IW-1:0] wr_idx;
        logic [PB-1:0] wr_base;
        logic [LW-1:0] wr_len;
        logic          clr_en;
        logic [IW-1:0] clr_idx;
    } cmd_t;

    localparam logic [PB+1:0] SPACE = (PB + 2)'(1) << PB;

    ctrl_state_t   state_reg, state_next;
    rec_t          head_reg, head_next;
    cmd_t          cmd_reg, cmd_next;
    rec_t          t;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_stat_reg, out_stat_next;
    logic [PB-1:0] out_page_reg, out_page_next;
    logic [1:0]    hold_stat_reg, hold_stat_next;
    logic [PB-1:0] hold_page_reg, hold_page_next;
    logic [1:0]    dec_stat;
    logic [PB-1:0] dec_page;
    cmd_t          dec_cmd;
    logic [PB+1:0] req_end;
    logic [PB+1:0] prev_end;
    logic          mprev;
    logic          mnext;
    logic          out_free;

    assign t        = rec_t'(rec_tail);
    assign rec_head = RW'(head_reg);
    assign cmd      = CW'(cmd_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODW'({out_page_reg, out_stat_reg});
    assign out_free = !out_valid_reg || m_tready;

    // Decide the request once its record leaves the last cell
    always_comb begin
        req_end  = {2'b00, t.base} + {1'b0, t.cnt};
        prev_end = {2'b00, t.p_base} + {1'b0, t.p_len};
        mprev    = t.p_ok && prev_end == {2'b00, t.base};
        mnext    = t.n_ok && {2'b00, t.n_base} == req_end;
        dec_stat = STAT_OK;
        dec_page = '0;
        dec_cmd  = '0;
        if (t.kind == KIND_ALLOC) begin
            if (t.cnt == '0 || !t.b_ok) begin
                dec_stat = STAT_NOFIT;
            end else begin
                dec_page = t.b_base;
                if (t.b_len == t.cnt) begin
                    dec_cmd.clr_en  = 1'b1;
                    dec_cmd.clr_idx = t.b_idx;
                end else begin
                    dec_cmd.wr_en   = 1'b1;
                    dec_cmd.wr_idx  = t.b_idx;
                    dec_cmd.wr_base = t.b_base + t.cnt[PB-1:0];
                    dec_cmd.wr_len  = t.b_len - t.cnt;
                end
            end
        end else if (t.cnt == '0) begin
            dec_stat = STAT_OK;
        end else if (req_end > SPACE) begin
            dec_stat = STAT_NOFIT;
        end else if (t.p_ok && {2'b00, t.base} < prev_end) begin
            dec_stat = STAT_DOUBLE;
        end else if (t.n_ok && req_end > {2'b00, t.n_base}) begin
            dec_stat = STAT_DOUBLE;
        end else if (mprev) begin
            dec_cmd.wr_en   = 1'b1;
            dec_cmd.wr_idx  = t.p_idx;
            dec_cmd.wr_base = t.p_base;
            if (mnext) begin
                dec_cmd.wr_len  = t.p_len + t.cnt + t.n_len;
                dec_cmd.clr_en  = 1'b1;
                dec_cmd.clr_idx = t.n_idx;
            end else begin
                dec_cmd.wr_len = t.p_len + t.cnt;
            end
        end else if (mnext) begin
            dec_cmd.wr_en   = 1'b1;
            dec_cmd.wr_idx  = t.n_idx;
            dec_cmd.wr_base = t.base;
            dec_cmd.wr_len  = t.n_len + t.cnt;
        end else if (!t.e_ok) begin
            dec_stat = STAT_FULL;
        end else begin
            dec_cmd.wr_en   = 1'b1;
            dec_cmd.wr_idx  = t.e_idx;
            dec_cmd.wr_base = t.base;
            dec_cmd.wr_len  = t.cnt;
        end
    end

    // Sequence requests and hold responses until taken
    always_comb begin
        state_next     = state_reg;
        head_next      = '0;
        cmd_next       = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_page_next  = out_page_reg;
        hold_stat_next = hold_stat_reg;
        hold_page_next = hold_page_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    head_next.act  = 1'b1;
                    head_next.kind = s_tuser;
                    head_next.base = s_tdata[PB-1:0];
                    head_next.cnt  = s_tdata[2*PB:PB];
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (t.act) begin
                    cmd_next = dec_cmd;
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_stat_next  = dec_stat;
                        out_page_next  = dec_page;
                        state_next     = S_IDLE;
                    end else begin
                        hold_stat_next = dec_stat;
                        hold_page_next = dec_page;
                        state_next     = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_stat_next  = hold_stat_reg;
                    out_page_next  = hold_page_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_stat_reg  <= out_stat_next;
        out_page_reg  <= out_page_next;
        hold_stat_reg <= hold_stat_next;
        hold_page_reg <= hold_page_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/best_fit_page_extent_allocator.sv @@
`default_nettype none
// Channel   Direction  tdata (low bit up)                  tuser
// s_        in         base_page, page_count, zero pad     kind
// m_        out        status, alloc_page, zero pad        -
//
// Each request walks a row of MAX_EXTENTS cells, one cell a cycle, through
// each cell's record register; the result is registered at the output, and the
// next request can be taken in the same cycle that the result becomes valid.
// One request is in flight at a time; s_tready is high only when idle.
// A result waiting on m_tready holds the next request off; the table update
// is already done. aresetn (synchronous) empties the table at once.
module best_fit_page_extent_allocator import bfpea_pkg::*; #(
    parameter int MAX_EXTENTS      = DEF_MAX_EXTENTS,
    parameter int PAGE_NUMBER_BITS = DEF_PAGE_NUMBER_BITS,
    localparam int IDW = ((2 * PAGE_NUMBER_BITS + 1 + 7) / 8) * 8,
    localparam int ODW = ((PAGE_NUMBER_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [IDW-1:0] s_tdata,   // base_page, page_count
    input  wire logic           s_tuser,   // kind
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [ODW-1:0] m_tdata    // status, alloc_page
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int RW = rec_width(PAGE_NUMBER_BITS, IW);
    localparam int CW = cmd_width(PAGE_NUMBER_BITS, IW);

    logic [RW-1:0] rec [MAX_EXTENTS+1];
    logic [CW-1:0] cmd;

    // Sequence requests and decide updates
    bfpea_ctrl #(
        .MAX_EXTENTS      (MAX_EXTENTS),
        .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .rec_head (rec[0]),
        .rec_tail (rec[MAX_EXTENTS]),
        .cmd      (cmd)
    );

    // Build the row of extent cells
    for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
        bfpea_cell #(
            .MAX_EXTENTS      (MAX_EXTENTS),
            .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS),
            .INDEX            (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .rec_in  (rec[i]),
            .rec_out (rec[i+1]),
            .cmd     (cmd)
        );
    end

endmodule
`default_nettype wire
